FILE: design/pts_pkg.sv
package pts_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = 8;
    localparam int PAL_CNT_W   = 9;
    localparam int LG_BASE     = 8;

    localparam logic [1:0] SIZE_CODE_MAX = 2'd2;
    localparam logic [7:0] ALPHA_DEFAULT = 8'h80;

    typedef enum logic [1:0] {
        KIND_PAL   = 2'd0,
        KIND_PIX   = 2'd1,
        KIND_DRAIN = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] out_data;
        logic        is_palette;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic is_palette;
        logic last;
    } t_rd_tag;

    // Swaps bytes 0 and 2 and replaces a zero alpha byte.
    function automatic logic [31:0] pal_format(input logic [31:0] word);
        logic [7:0] alpha;
        begin
            alpha = (word[31:24] == 8'h00) ? ALPHA_DEFAULT : word[31:24];
            return {alpha, word[7:0], word[15:8], word[23:16]};
        end
    endfunction

endpackage

FILE: design/pts_if.sv
interface pts_in_if;
    import pts_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] in_data;
    modport source (output valid, output kind, output in_data, input ready);
    modport sink   (input valid, input kind, input in_data, output ready);
endinterface

interface pts_out_if;
    import pts_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic        is_palette;
    logic        last;
    modport source (output valid, output out_data, output is_palette, output last,
                    input ready);
    modport sink   (input valid, input out_data, input is_palette, input last,
                    output ready);
endinterface

interface pts_cfg_if;
    import pts_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] size_code;
    modport source (output valid, output size_code, input ready);
    modport sink   (input valid, input size_code, output ready);
endinterface

FILE: design/pts_ram.sv
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/pts_addr_gen.sv
module pts_addr_gen #(
    parameter int SIDE_W = 8
) (
    input  logic [2*SIDE_W-1:0]         i_pix_idx,
    input  logic [$clog2(SIDE_W+1)-1:0] i_lg,
    input  logic [pts_pkg::PAL_AW-1:0]  i_pal_idx,
    output logic [2*SIDE_W-1:0]         o_pix_src,
    output logic [pts_pkg::PAL_AW-1:0]  o_pal_src
);
    import pts_pkg::*;

    localparam int AW = 2 * SIDE_W;

    logic [AW-1:0] w, r, c, dr, dc, cr, bc, ac, crm2;
    logic          flip;

    // Entries 8..15 and 16..23 of each bank trade places: bits 4 and 3 swap.
    assign o_pal_src = {i_pal_idx[PAL_AW-1:5], i_pal_idx[3], i_pal_idx[4], i_pal_idx[2:0]};

    always_comb begin
        w    = AW'(1) << i_lg;
        r    = i_pix_idx >> i_lg;
        c    = i_pix_idx & (w - AW'(1));
        dr   = {r[AW-1:1], c[0]};
        dc   = (c >> 1) | (r[0] ? (w >> 1) : '0);
        cr   = {dr[AW-1:2], dr[0], dr[1]};
        bc   = {dc[AW-1:4], dc[0], dc[3:1]};
        crm2 = cr - AW'(2);
        flip = (cr >= AW'(2)) && ((cr + AW'(2)) < w) && !crm2[2];
        ac   = bc ^ (AW'(flip) << 2);
        o_pix_src = ((w - AW'(1) - cr) << i_lg) | ac;
    end
endmodule

FILE: design/palettized_texture_swizzler.sv
// Palettized texture swizzler. Load 256 palette words (kind 0) and side*side pixel
// bytes in bottom-up row order (kind 1); each drain beat (kind 2) then returns one
// output: first the 256 reordered palette words, then the swizzled pixels, with last
// set on the final pixel. Surplus loads and drains are dropped without a result.
// The block takes one beat per cycle unless input is held off. A drain's result is first
// registered by the read port of the palette or pixel memory and then by the output
// register. These two registers together hold two results, so input is held off only
// while both are full and the output is stalled. Memories are not cleared
// after reset, and size_code must be written only while the block is idle.
module palettized_texture_swizzler #(
    parameter int MAX_SIDE = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pts_in_if.sink    i_in,
    pts_cfg_if.sink   i_cfg,
    pts_out_if.source o_out
);
    import pts_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE);
    localparam int AW     = 2 * SIDE_W;
    localparam int CW     = AW + 1;
    localparam int LG_W   = $clog2(SIDE_W + 1);

    logic [1:0]           r_size_code;
    logic [PAL_CNT_W-1:0] r_pal_cnt, n_pal_cnt;
    logic [CW-1:0]        r_pix_cnt, n_pix_cnt;
    logic [CW-1:0]        r_drain_cnt, n_drain_cnt;
    logic                 r_rd_vld, n_rd_vld;
    t_rd_tag              r_rd_tag, n_rd_tag;
    logic                 r_out_vld, n_out_vld;
    t_out_beat            r_out, n_out;

    logic [1:0]      sc;
    logic [LG_W-1:0] lg;
    logic [LG_W:0]   lg_full;
    logic [CW-1:0]   total, total_m1, pix_pos;
    logic [AW-1:0]   pix_idx, pix_src;
    logic [PAL_AW-1:0] pal_src;
    logic            stall, in_fire, pal_we, pix_we, drain_go, rd_pal, rd_adv;
    logic [31:0]     pal_rdata;
    logic [7:0]      pix_rdata;

    always_comb begin
        sc      = (r_size_code > SIZE_CODE_MAX) ? SIZE_CODE_MAX : r_size_code;
        lg_full = (LG_W + 1)'(LG_BASE) + (LG_W + 1)'(sc);
        lg      = (lg_full > (LG_W + 1)'(SIDE_W)) ? LG_W'(SIDE_W) : lg_full[LG_W-1:0];
        total   = CW'(1) << {lg, 1'b0};
        total_m1 = total - CW'(1);
        pix_pos = r_drain_cnt - CW'(PAL_ENTRIES);
        pix_idx = pix_pos[AW-1:0];
    end

    pts_addr_gen #(.SIDE_W(SIDE_W)) u_addr_gen (
        .i_pix_idx (pix_idx),
        .i_lg      (lg),
        .i_pal_idx (r_drain_cnt[PAL_AW-1:0]),
        .o_pix_src (pix_src),
        .o_pal_src (pal_src)
    );

    assign stall      = r_rd_vld && r_out_vld && !o_out.ready;
    assign i_in.ready = !stall;
    assign i_cfg.ready = 1'b1;
    assign in_fire    = i_in.valid && !stall;
    assign rd_adv     = r_rd_vld && !stall;

    always_comb begin
        pal_we   = 1'b0;
        pix_we   = 1'b0;
        drain_go = 1'b0;
        if (in_fire) begin
            case (i_in.kind)
                KIND_PAL: begin
                    pal_we = !r_pal_cnt[PAL_CNT_W-1];
                end
                KIND_PIX: begin
                    pix_we = r_pix_cnt < total;
                end
                KIND_DRAIN: begin
                    drain_go = r_drain_cnt < (CW'(PAL_ENTRIES) + total);
                end
                default: begin
                end
            endcase
        end
        rd_pal = drain_go && (r_drain_cnt < CW'(PAL_ENTRIES));
    end

    pts_ram #(.WIDTH(32), .DEPTH(PAL_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_pal_cnt[PAL_AW-1:0]),
        .i_wdata (i_in.in_data),
        .i_re    (rd_pal),
        .i_raddr (pal_src),
        .o_rdata (pal_rdata)
    );

    pts_ram #(.WIDTH(8), .DEPTH(MAX_SIDE * MAX_SIDE)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (r_pix_cnt[AW-1:0]),
        .i_wdata (i_in.in_data[7:0]),
        .i_re    (drain_go && !rd_pal),
        .i_raddr (pix_src),
        .o_rdata (pix_rdata)
    );

    always_comb begin
        n_pal_cnt   = r_pal_cnt + PAL_CNT_W'(pal_we);
        n_pix_cnt   = r_pix_cnt + CW'(pix_we);
        n_drain_cnt = r_drain_cnt + CW'(drain_go);
        n_rd_vld    = r_rd_vld;
        n_rd_tag    = r_rd_tag;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        if (rd_adv) begin
            n_out_vld = 1'b1;
            n_out.is_palette = r_rd_tag.is_palette;
            n_out.last       = r_rd_tag.last;
            n_out.out_data   = r_rd_tag.is_palette ? pal_format(pal_rdata)
                                                   : {24'h000000, pix_rdata};
            n_rd_vld = 1'b0;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
        if (drain_go) begin
            n_rd_vld            = 1'b1;
            n_rd_tag.is_palette = rd_pal;
            n_rd_tag.last       = !rd_pal && (pix_pos == total_m1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_code <= '0;
            r_pal_cnt   <= '0;
            r_pix_cnt   <= '0;
            r_drain_cnt <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_size_code <= i_cfg.size_code;
            end
            r_pal_cnt   <= n_pal_cnt;
            r_pix_cnt   <= n_pix_cnt;
            r_drain_cnt <= n_drain_cnt;
            r_rd_vld    <= n_rd_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag <= n_rd_tag;
        r_out    <= n_out;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_data   = r_out.out_data;
    assign o_out.is_palette = r_out.is_palette;
    assign o_out.last       = r_out.last;

    a_last_is_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.last |-> !r_out.is_palette)
        else $error("last flagged on a palette beat");

    a_pal_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pal_cnt <= PAL_CNT_W'(PAL_ENTRIES))
        else $error("palette load count overran");

    a_drain_reads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_go |=> r_rd_vld)
        else $error("accepted drain lost its memory read");

    a_held_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> r_rd_vld && r_out_vld)
        else $error("stalled result dropped");
endmodule
